// ===== rtl/core/hsbe_pkg.sv =====
`timescale 1ns / 1ps

package hsbe_pkg;

    localparam int MAX_HOT_ENTRIES = 36;
    localparam int DEF_HOT_ENTRIES = 36;
    localparam int TABLE_BITS      = MAX_HOT_ENTRIES * 8;
    localparam int IDX_W           = 6;
    localparam int TIER1_START     = 4;
    localparam int TIER2_START     = 20;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOT0,
        REG_HOT1,
        REG_HOT2,
        REG_HOT3,
        REG_HOT4,
        REG_COLD_BASE,
        REG_COLD_WSEL,
        REG_BYPASS
    } cfg_reg_t;

    typedef enum logic [2:0] {
        KIND_RAW,
        KIND_TIER0,
        KIND_TIER1,
        KIND_TIER2,
        KIND_ESCAPE
    } kind_t;

    typedef enum logic [2:0] {
        WSEL_NONE,
        WSEL_TWO,
        WSEL_FOUR,
        WSEL_SIX,
        WSEL_EIGHT
    } wsel_t;

    typedef struct packed {
        logic [7:0] cold_base;
        logic [2:0] width_sel;
        logic       bypass;
    } coder_cfg_t;

    typedef struct packed {
        kind_t      kind;
        logic [3:0] len;
        logic [9:0] word;
    } code_t;

endpackage

// ===== rtl/core/hsbe_match.sv =====
`timescale 1ns / 1ps

// Stage 1: compare the byte with every hot entry at once.
module hsbe_match
    import hsbe_pkg::*;
#(
    parameter int HOT_ENTRIES = DEF_HOT_ENTRIES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [TABLE_BITS-1:0]  hot_table,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_sym,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_sym,
    output logic [HOT_ENTRIES-1:0] out_match
);

    logic                   valid_reg;
    logic                   valid_next;
    logic [7:0]             sym_reg;
    logic [HOT_ENTRIES-1:0] match_reg;
    logic [HOT_ENTRIES-1:0] match_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_comb
    begin
        for (int k = 0; k < HOT_ENTRIES; k++)
        begin
            match_next[k] = (hot_table[k*8 +: 8] == in_sym);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sym_reg   <= in_sym;
            match_reg <= match_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sym   = sym_reg;
    assign out_match = match_reg;

endmodule

// ===== rtl/core/hsbe_group.sv =====
`timescale 1ns / 1ps

// Stage 2: first hit inside each group of eight entries.
module hsbe_group
    import hsbe_pkg::*;
#(
    parameter int HOT_ENTRIES = DEF_HOT_ENTRIES,
    localparam int GROUPS     = (HOT_ENTRIES + 7) / 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             in_sym,
    input  logic [HOT_ENTRIES-1:0] in_match,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_sym,
    output logic [GROUPS-1:0]      out_any,
    output logic [GROUPS*3-1:0]    out_off
);

    localparam int PAD_W = GROUPS * 8;

    logic                  valid_reg;
    logic                  valid_next;
    logic [7:0]            sym_reg;
    logic [GROUPS-1:0]     any_reg;
    logic [GROUPS-1:0]     any_next;
    logic [GROUPS*3-1:0]   off_reg;
    logic [GROUPS*3-1:0]   off_next;
    logic [PAD_W-1:0]      pad;

    assign pad      = PAD_W'(in_match);
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            any_next[g]        = |pad[g*8 +: 8];
            off_next[g*3 +: 3] = 3'd0;
            // scan downward so the lowest set bit wins
            for (int j = 7; j >= 0; j--)
            begin
                if (pad[g*8 + j])
                begin
                    off_next[g*3 +: 3] = 3'(j);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            sym_reg <= in_sym;
            any_reg <= any_next;
            off_reg <= off_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sym   = sym_reg;
    assign out_any   = any_reg;
    assign out_off   = off_reg;

endmodule

// ===== rtl/core/hsbe_format.sv =====
`timescale 1ns / 1ps

// Stage 3: pick the first hit group, build the code word, output register.
module hsbe_format
    import hsbe_pkg::*;
#(
    parameter int HOT_ENTRIES = DEF_HOT_ENTRIES,
    localparam int GROUPS     = (HOT_ENTRIES + 7) / 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  coder_cfg_t          cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_sym,
    input  logic [GROUPS-1:0]   in_any,
    input  logic [GROUPS*3-1:0] in_off,
    output logic                out_valid,
    input  logic                out_ready,
    output code_t               out_code
);

    logic             valid_reg;
    logic             valid_next;
    code_t            code_reg;
    code_t            code_next;
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] tier_off;
    logic [7:0]       res;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_comb
    begin
        hit = |in_any;
        idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (in_any[g])
            begin
                idx = IDX_W'(g * 8) + {{(IDX_W-3){1'b0}}, in_off[g*3 +: 3]};
            end
        end
    end

    always_comb
    begin
        tier_off = (idx < IDX_W'(TIER2_START)) ? (idx - IDX_W'(TIER1_START))
                                                : (idx - IDX_W'(TIER2_START));
        res = in_sym - cfg.cold_base;
        code_next.word = '0;
        code_next.len  = 4'd2;
        code_next.kind = KIND_ESCAPE;
        if (cfg.bypass)
        begin
            code_next.word = {2'b00, in_sym};
            code_next.len  = 4'd8;
            code_next.kind = KIND_RAW;
        end
        else if (hit && (idx < IDX_W'(TIER1_START)))
        begin
            code_next.word = {8'd0, idx[1:0]};
            code_next.len  = 4'd4;
            code_next.kind = KIND_TIER0;
        end
        else if (hit && (idx < IDX_W'(TIER2_START)))
        begin
            code_next.word = {4'd0, 2'b01, tier_off[3:0]};
            code_next.len  = 4'd6;
            code_next.kind = KIND_TIER1;
        end
        else if (hit)
        begin
            code_next.word = {4'd0, 2'b10, tier_off[3:0]};
            code_next.len  = 4'd6;
            code_next.kind = KIND_TIER2;
        end
        else
        begin
            // escape: control 3 then the rebased byte cut to the chosen width
            case (wsel_t'(cfg.width_sel))
                WSEL_TWO:
                begin
                    code_next.word = {6'd0, 2'b11, res[1:0]};
                    code_next.len  = 4'd4;
                end
                WSEL_FOUR:
                begin
                    code_next.word = {4'd0, 2'b11, res[3:0]};
                    code_next.len  = 4'd6;
                end
                WSEL_SIX:
                begin
                    code_next.word = {2'd0, 2'b11, res[5:0]};
                    code_next.len  = 4'd8;
                end
                WSEL_EIGHT:
                begin
                    code_next.word = {2'b11, res};
                    code_next.len  = 4'd10;
                end
                default:
                begin
                    code_next.word = {8'd0, 2'b11};
                    code_next.len  = 4'd2;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            code_reg <= code_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_code  = code_reg;

endmodule

// ===== rtl/core/hot_symbol_byte_encoder.sv =====
`timescale 1ns / 1ps

// Byte to variable-length code encoder. Each byte on the input stream gives
// one code word: raw 8 bits in bypass mode, otherwise a 2-bit control plus
// the index of the first matching hot table entry (tiers at indexes 0-3,
// 4-19, 20-35), or an escape carrying the byte minus cold_base cut to 0-8
// bits. The code sits right aligned in tdata with its length above it; the
// kind travels on tuser. Three register stages (compare, per-group priority,
// final select and format), one byte per cycle sustained while the output
// is not stalled. A stall on the output backs up through the stage valid
// bits with nothing lost. Configuration writes are taken at any time on the
// cfg port but must only be issued while the pipe is empty.
module hot_symbol_byte_encoder
    import hsbe_pkg::*;
#(
    parameter int HOT_ENTRIES = DEF_HOT_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] byte_in
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [15:0]           m_axis_tdata,   // [9:0] code_word, [13:10] code_length
    output logic [2:0]            m_axis_tuser,   // [2:0] code_kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int GROUPS = (HOT_ENTRIES + 7) / 8;

    logic [TABLE_BITS-1:0] hot_table_reg;
    coder_cfg_t            cfg_reg;

    logic                   s1_valid;
    logic                   s1_ready;
    logic [7:0]             s1_sym;
    logic [HOT_ENTRIES-1:0] s1_match;
    logic                   s2_valid;
    logic                   s2_ready;
    logic [7:0]             s2_sym;
    logic [GROUPS-1:0]      s2_any;
    logic [GROUPS*3-1:0]    s2_off;
    code_t                  code;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hot_table_reg <= '0;
            cfg_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_HOT0:      hot_table_reg[0   +: 64] <= cfg_data;
                REG_HOT1:      hot_table_reg[64  +: 64] <= cfg_data;
                REG_HOT2:      hot_table_reg[128 +: 64] <= cfg_data;
                REG_HOT3:      hot_table_reg[192 +: 64] <= cfg_data;
                REG_HOT4:      hot_table_reg[256 +: 32] <= cfg_data[31:0];
                REG_COLD_BASE: cfg_reg.cold_base        <= cfg_data[7:0];
                REG_COLD_WSEL: cfg_reg.width_sel        <= cfg_data[2:0];
                REG_BYPASS:    cfg_reg.bypass           <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    hsbe_match #(
        .HOT_ENTRIES (HOT_ENTRIES)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .hot_table (hot_table_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sym    (s_axis_tdata),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_sym   (s1_sym),
        .out_match (s1_match)
    );

    hsbe_group #(
        .HOT_ENTRIES (HOT_ENTRIES)
    ) u_group (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_sym    (s1_sym),
        .in_match  (s1_match),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_sym   (s2_sym),
        .out_any   (s2_any),
        .out_off   (s2_off)
    );

    hsbe_format #(
        .HOT_ENTRIES (HOT_ENTRIES)
    ) u_format (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_sym    (s2_sym),
        .in_any    (s2_any),
        .in_off    (s2_off),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_code  (code)
    );

    assign m_axis_tdata = {2'b00, code.len, code.word};
    assign m_axis_tuser = code.kind;

endmodule

// ===== rtl/core/hsbe_checker.sv =====
`timescale 1ns / 1ps

module hsbe_checker
    import hsbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [2:0]  m_axis_tuser
);

    // nothing comes out while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output request during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output changed");

    // an open output lets the whole pipe move
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output ready");

    a_kind_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser == KIND_RAW) && (m_axis_tdata[13:10] == 4'd8))
            || ((m_axis_tuser == KIND_TIER0) && (m_axis_tdata[13:10] == 4'd4))
            || ((m_axis_tuser == KIND_TIER1) && (m_axis_tdata[13:10] == 4'd6))
            || ((m_axis_tuser == KIND_TIER2) && (m_axis_tdata[13:10] == 4'd6))
            || ((m_axis_tuser == KIND_ESCAPE) && (m_axis_tdata[13:10] >= 4'd2)
                && (m_axis_tdata[13:10] <= 4'd10) && !m_axis_tdata[10]))
        else $error("code kind and length disagree");

    a_tier_control: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == KIND_TIER1) || (m_axis_tuser == KIND_TIER2))
            |-> (m_axis_tdata[9:6] == 4'd0)
                && (m_axis_tdata[5:4] == ((m_axis_tuser == KIND_TIER1) ? 2'b01 : 2'b10)))
        else $error("tier control bits wrong");

endmodule

bind hot_symbol_byte_encoder hsbe_checker u_hsbe_checker (.*);
